@@ src/nvds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvds_pkg
// shared widths, register indexes, conversion constants and types for the
// nearest-neighbour downscaler with yuv to rgb conversion
// ----------------------------------------------------------------------------
package nvds_pkg;

  localparam int DIM_BITS = 12;
  localparam int CNT_BITS = $clog2(DIM_BITS + 1);
  localparam int PIX_BITS = 8;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = DIM_BITS;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT = CFG_IDX_BITS'(3);
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWAP       = CFG_IDX_BITS'(4);

  // register reset values
  localparam logic [DIM_BITS-1:0] RST_SRC_WIDTH  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] RST_SRC_HEIGHT = DIM_BITS'(480);
  localparam logic [DIM_BITS-1:0] RST_DST_WIDTH  = DIM_BITS'(256);
  localparam logic [DIM_BITS-1:0] RST_DST_HEIGHT = DIM_BITS'(256);

  // bt.601 full range, q16
  localparam int Q_SHIFT   = 16;
  localparam int PROD_BITS = 26;
  localparam int CH_BITS   = PROD_BITS - Q_SHIFT + 2;

  localparam logic signed [PROD_BITS-1:0] K_RV = PROD_BITS'(91881);
  localparam logic signed [PROD_BITS-1:0] K_GU = PROD_BITS'(22554);
  localparam logic signed [PROD_BITS-1:0] K_GV = PROD_BITS'(46802);
  localparam logic signed [PROD_BITS-1:0] K_BU = PROD_BITS'(116130);
  localparam logic signed [PIX_BITS:0]    CHROMA_OFS = (PIX_BITS + 1)'(128);

  typedef logic [DIM_BITS-1:0] dim_t;

  typedef struct packed {
    logic run;
    logic done;
  } div_stat_t;

endpackage

@@ src/nvds_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvds_div
// restoring divider, one quotient bit per cycle, for the step constants
// ----------------------------------------------------------------------------
module nvds_div import nvds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start_i,
  input  dim_t      dividend_i,
  input  dim_t      divisor_i,
  output div_stat_t stat_o,
  output dim_t      quotient_o,
  output dim_t      remainder_o
);

  logic                run_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  dim_t                rem_r;
  dim_t                quo_r;
  dim_t                dvs_r;

  logic [DIM_BITS:0]   shifted;
  dim_t                rem_nxt;
  dim_t                quo_nxt;
  logic                last_step;

  assign last_step = run_r && (cnt_r == CNT_BITS'(1));

  always_comb begin
    shifted = {rem_r, quo_r[DIM_BITS-1]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = DIM_BITS'(shifted - {1'b0, dvs_r});
      quo_nxt = {quo_r[DIM_BITS-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIM_BITS-1:0];
      quo_nxt = {quo_r[DIM_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step && !start_i;
      if (start_i) begin
        run_r <= 1'b1;
        cnt_r <= CNT_BITS'(DIM_BITS);
      end else if (run_r) begin
        run_r <= !last_step;
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      quo_r <= dividend_i;
      dvs_r <= divisor_i;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat_o      = '{run: run_r, done: done_r};
  assign quotient_o  = quo_r;
  assign remainder_o = rem_r;

endmodule

@@ src/nv12_nearest_downscale_to_rgb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv12_nearest_downscale_to_rgb
// streaming nearest-neighbour downscaler with bt.601 full-range yuv to rgb
// ----------------------------------------------------------------------------
// Source pixels come in raster order, one per transaction, each carrying luma
// and its co-sited 4:2:0 chroma pair; in_tuser marks the first pixel of a
// frame. A pixel that falls on a picked row and column (floor(d*src/dst)) is
// converted to rgb and sent out in b,g,r order (r,g,b with swap off), with
// out_tlast on the last output pixel of the frame. The block takes one pixel
// per clock while in_tready is high; a result passes through stage 1, stage 2
// and the output register. After reset and after every configuration write,
// in_tready stays low while bit-serial dividers work out the row and column
// step quotients and reduce the stored remainders; sizes must be written only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module nv12_nearest_downscale_to_rgb import nvds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // source pixels
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [3*PIX_BITS-1:0]    in_tdata,   // luma, chroma_u, chroma_v
  input  logic                     in_tuser,   // frame_start
  // converted pixels
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [3*PIX_BITS-1:0]    out_tdata,  // first_channel, green_channel,
                                               // third_channel
  output logic                     out_tlast,  // frame_end
  // register writes
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  dim_t src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic swap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_WIDTH;
      src_h_r <= RST_SRC_HEIGHT;
      dst_w_r <= RST_DST_WIDTH;
      dst_h_r <= RST_DST_HEIGHT;
      swap_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        CFG_SWAP:       swap_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective sizes: zero reads as one, target saturated to source
  dim_t sw_eff, sh_eff, tw_eff, th_eff;
  dim_t tw_nz, th_nz;

  always_comb begin
    sw_eff = (src_w_r == '0) ? DIM_BITS'(1) : src_w_r;
    sh_eff = (src_h_r == '0) ? DIM_BITS'(1) : src_h_r;
    tw_nz  = (dst_w_r == '0) ? DIM_BITS'(1) : dst_w_r;
    th_nz  = (dst_h_r == '0) ? DIM_BITS'(1) : dst_h_r;
    tw_eff = (tw_nz > sw_eff) ? sw_eff : tw_nz;
    th_eff = (th_nz > sh_eff) ? sh_eff : th_nz;
  end

  // --------------------------------------------------------------------------
  // step constants: src = q * dst + r, and the stored remainders brought
  // back below the (possibly new) target size
  // --------------------------------------------------------------------------
  logic      recalc_r;
  logic      div_start;
  div_stat_t st_cw, st_rh, st_cr, st_rr;
  dim_t      col_q, col_r, row_q, row_r;
  dim_t      crem_q, crem_r, rrem_q, rrem_r;
  logic      busy_w;
  logic      load_rem;

  // storage for the running pick state; *_rem_r is the full remainder,
  // *_red_r and *_ext_r its split against the current target size
  dim_t src_col_r, dst_col_r, pick_col_r, col_rem_r, col_red_r, col_ext_r;
  dim_t src_row_r, dst_row_r, pick_row_r, row_rem_r, row_red_r, row_ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recalc_r <= 1'b1;
    end else if (cfg_we) begin
      recalc_r <= 1'b1;
    end else begin
      recalc_r <= 1'b0;
    end
  end

  assign div_start = recalc_r && !cfg_we;
  assign load_rem  = st_cr.done;
  assign busy_w    = recalc_r || st_cw.run || st_rh.run || st_cr.run || st_rr.run
                   || st_cw.done || st_rh.done || st_cr.done || st_rr.done;

  nvds_div u_div_col (
    .clk, .rst_n, .start_i(div_start), .dividend_i(sw_eff), .divisor_i(tw_eff),
    .stat_o(st_cw), .quotient_o(col_q), .remainder_o(col_r)
  );

  nvds_div u_div_row (
    .clk, .rst_n, .start_i(div_start), .dividend_i(sh_eff), .divisor_i(th_eff),
    .stat_o(st_rh), .quotient_o(row_q), .remainder_o(row_r)
  );

  nvds_div u_div_crem (
    .clk, .rst_n, .start_i(div_start), .dividend_i(col_rem_r), .divisor_i(tw_eff),
    .stat_o(st_cr), .quotient_o(crem_q), .remainder_o(crem_r)
  );

  nvds_div u_div_rrem (
    .clk, .rst_n, .start_i(div_start), .dividend_i(row_rem_r), .divisor_i(th_eff),
    .stat_o(st_rr), .quotient_o(rrem_q), .remainder_o(rrem_r)
  );

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage moves when the next one has room
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_rdy, s2_rdy, s1_rdy;
  logic fire;

  assign out_rdy   = !out_valid_r || out_tready;
  assign s2_rdy    = !s2_valid_r || out_rdy;
  assign s1_rdy    = !s1_valid_r || s2_rdy;
  assign in_tready = !busy_w && s1_rdy;
  assign fire      = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // position counters and picks
  // --------------------------------------------------------------------------
  logic row_rst, col_rst;
  dim_t c_scol, c_dcol, c_pcol, c_crem, c_cred, c_cext;
  dim_t c_srow, c_drow, c_prow, c_rrem, c_rred, c_rext;
  logic row_hit, col_hit, hit, pix_last;
  logic [DIM_BITS:0] csum, rsum;
  logic cc, rc;
  dim_t cpick_step, crem_step, rpick_step, rrem_step;

  dim_t src_col_nxt, dst_col_nxt, pick_col_nxt, col_rem_nxt, col_red_nxt, col_ext_nxt;
  dim_t src_row_nxt, dst_row_nxt, pick_row_nxt, row_rem_nxt, row_red_nxt, row_ext_nxt;

  always_comb begin
    // restart on frame start, or when the position ran past the frame
    row_rst = in_tuser || (src_row_r >= sh_eff);
    col_rst = row_rst || (src_col_r >= sw_eff);

    c_srow = row_rst ? '0 : src_row_r;
    c_drow = row_rst ? '0 : dst_row_r;
    c_prow = row_rst ? '0 : pick_row_r;
    c_rrem = row_rst ? '0 : row_rem_r;
    c_rred = row_rst ? '0 : row_red_r;
    c_rext = row_rst ? '0 : row_ext_r;
    c_scol = col_rst ? '0 : src_col_r;
    c_dcol = col_rst ? '0 : dst_col_r;
    c_pcol = col_rst ? '0 : pick_col_r;
    c_crem = col_rst ? '0 : col_rem_r;
    c_cred = col_rst ? '0 : col_red_r;
    c_cext = col_rst ? '0 : col_ext_r;

    row_hit  = (c_srow == c_prow) && (c_drow < th_eff);
    col_hit  = (c_scol == c_pcol) && (c_dcol < tw_eff);
    hit      = row_hit && col_hit;
    pix_last = ({1'b0, c_drow} + (DIM_BITS + 1)'(1) == {1'b0, th_eff})
            && ({1'b0, c_dcol} + (DIM_BITS + 1)'(1) == {1'b0, tw_eff});

    // next pick: remainder stays below the target, so one compare carries
    csum       = {1'b0, c_cred} + {1'b0, col_r};
    cc         = csum >= {1'b0, tw_eff};
    crem_step  = cc ? DIM_BITS'(csum - {1'b0, tw_eff}) : csum[DIM_BITS-1:0];
    cpick_step = c_pcol + c_cext + col_q + DIM_BITS'(cc);

    rsum       = {1'b0, c_rred} + {1'b0, row_r};
    rc         = rsum >= {1'b0, th_eff};
    rrem_step  = rc ? DIM_BITS'(rsum - {1'b0, th_eff}) : rsum[DIM_BITS-1:0];
    rpick_step = c_prow + c_rext + row_q + DIM_BITS'(rc);

    src_col_nxt  = src_col_r;
    dst_col_nxt  = dst_col_r;
    pick_col_nxt = pick_col_r;
    col_rem_nxt  = col_rem_r;
    col_red_nxt  = col_red_r;
    col_ext_nxt  = col_ext_r;
    src_row_nxt  = src_row_r;
    dst_row_nxt  = dst_row_r;
    pick_row_nxt = pick_row_r;
    row_rem_nxt  = row_rem_r;
    row_red_nxt  = row_red_r;
    row_ext_nxt  = row_ext_r;

    if (fire) begin
      src_col_nxt  = c_scol;
      dst_col_nxt  = c_dcol;
      pick_col_nxt = c_pcol;
      col_rem_nxt  = c_crem;
      col_red_nxt  = c_cred;
      col_ext_nxt  = c_cext;
      src_row_nxt  = c_srow;
      dst_row_nxt  = c_drow;
      pick_row_nxt = c_prow;
      row_rem_nxt  = c_rrem;
      row_red_nxt  = c_rred;
      row_ext_nxt  = c_rext;

      if (hit) begin
        dst_col_nxt  = c_dcol + DIM_BITS'(1);
        pick_col_nxt = cpick_step;
        col_rem_nxt  = crem_step;
        col_red_nxt  = crem_step;
        col_ext_nxt  = '0;
      end

      if ({1'b0, c_scol} + (DIM_BITS + 1)'(1) >= {1'b0, sw_eff}) begin
        // end of source row
        src_col_nxt  = '0;
        dst_col_nxt  = '0;
        pick_col_nxt = '0;
        col_rem_nxt  = '0;
        col_red_nxt  = '0;
        col_ext_nxt  = '0;
        if (row_hit) begin
          dst_row_nxt  = c_drow + DIM_BITS'(1);
          pick_row_nxt = rpick_step;
          row_rem_nxt  = rrem_step;
          row_red_nxt  = rrem_step;
          row_ext_nxt  = '0;
        end
        if ({1'b0, c_srow} + (DIM_BITS + 1)'(1) >= {1'b0, sh_eff}) begin
          src_row_nxt  = '0;
          dst_row_nxt  = '0;
          pick_row_nxt = '0;
          row_rem_nxt  = '0;
          row_red_nxt  = '0;
          row_ext_nxt  = '0;
        end else begin
          src_row_nxt = c_srow + DIM_BITS'(1);
        end
      end else begin
        src_col_nxt = c_scol + DIM_BITS'(1);
      end
    end else if (load_rem) begin
      // whole multiples of the target go into the next pick step
      col_red_nxt = crem_r;
      col_ext_nxt = crem_q;
      row_red_nxt = rrem_r;
      row_ext_nxt = rrem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r  <= '0;
      dst_col_r  <= '0;
      pick_col_r <= '0;
      col_rem_r  <= '0;
      col_red_r  <= '0;
      col_ext_r  <= '0;
      src_row_r  <= '0;
      dst_row_r  <= '0;
      pick_row_r <= '0;
      row_rem_r  <= '0;
      row_red_r  <= '0;
      row_ext_r  <= '0;
    end else begin
      src_col_r  <= src_col_nxt;
      dst_col_r  <= dst_col_nxt;
      pick_col_r <= pick_col_nxt;
      col_rem_r  <= col_rem_nxt;
      col_red_r  <= col_red_nxt;
      col_ext_r  <= col_ext_nxt;
      src_row_r  <= src_row_nxt;
      dst_row_r  <= dst_row_nxt;
      pick_row_r <= pick_row_nxt;
      row_rem_r  <= row_rem_nxt;
      row_red_r  <= row_red_nxt;
      row_ext_r  <= row_ext_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: picked pixel
  // --------------------------------------------------------------------------
  logic [PIX_BITS-1:0] s1_y_r, s1_u_r, s1_v_r;
  logic                s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= fire && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_y_r    <= in_tdata[PIX_BITS-1:0];
      s1_u_r    <= in_tdata[2*PIX_BITS-1:PIX_BITS];
      s1_v_r    <= in_tdata[3*PIX_BITS-1:2*PIX_BITS];
      s1_last_r <= pix_last;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: q16 chroma products
  // --------------------------------------------------------------------------
  logic signed [PIX_BITS:0]    u_s, v_s;
  logic signed [PROD_BITS-1:0] u_x, v_x;
  logic signed [PROD_BITS-1:0] s2_pr_r, s2_pg_r, s2_pb_r;
  logic [PIX_BITS-1:0]         s2_y_r;
  logic                        s2_last_r;

  assign u_s = signed'({1'b0, s1_u_r}) - CHROMA_OFS;
  assign v_s = signed'({1'b0, s1_v_r}) - CHROMA_OFS;
  assign u_x = PROD_BITS'(u_s);
  assign v_x = PROD_BITS'(v_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_pr_r   <= K_RV * v_x;
      s2_pg_r   <= K_GU * u_x + K_GV * v_x;
      s2_pb_r   <= K_BU * u_x;
      s2_y_r    <= s1_y_r;
      s2_last_r <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: floor, add luma, clamp, channel order
  // --------------------------------------------------------------------------
  function automatic logic [PIX_BITS-1:0] clamp_byte(input logic signed [CH_BITS-1:0] x);
    logic [PIX_BITS-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > CH_BITS'(255)) begin
      res = '1;
    end else begin
      res = x[PIX_BITS-1:0];
    end
    return res;
  endfunction

  logic signed [CH_BITS-1:0] y_x, r_s, g_s, b_s;
  logic [PIX_BITS-1:0]       r_c, g_c, b_c;
  logic [3*PIX_BITS-1:0]     out_data_r;
  logic                      out_last_r;

  always_comb begin
    y_x = CH_BITS'(signed'({1'b0, s2_y_r}));
    r_s = y_x + CH_BITS'(s2_pr_r >>> Q_SHIFT);
    g_s = y_x - CH_BITS'(s2_pg_r >>> Q_SHIFT);
    b_s = y_x + CH_BITS'(s2_pb_r >>> Q_SHIFT);
    r_c = clamp_byte(r_s);
    g_c = clamp_byte(g_s);
    b_c = clamp_byte(b_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_data_r <= swap_r ? {r_c, g_c, b_c} : {b_c, g_c, r_c};
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // all divider lanes start together and finish in the same cycle
  a_lanes_done: assert property (@(posedge clk) disable iff (!rst_n)
    st_cw.done |-> (st_rh.done && st_cr.done && st_rr.done))
    else $error("divider lanes out of step");

  // single compare-subtract step needs the remainders below the target
  a_col_rem: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_w |-> (col_red_r < tw_eff))
    else $error("column remainder not below target width");

  a_row_rem: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_w |-> (row_red_r < th_eff))
    else $error("row remainder not below target height");

  // no pixel taken while step constants are being worked out
  a_no_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_cw.run || recalc_r) |=> !$rose(s1_valid_r))
    else $error("pixel picked during recalculation");

endmodule
